// ===== design/mts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg
// Shared codes and controller/datapath interface types for the min-tracking
// stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE    = 2'b01,
        S_POP_FIN = 2'b10
    } mts_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input item taken this cycle
        logic fin;      // pop read data is back, update tops
        logic load;     // load result register
    } mts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pop_go;   // offered item is a pop on a non-empty stack
        logic out_free; // result register free or being drained
    } mts_stat_t;

endpackage
`default_nettype wire

// ===== design/min_tracking_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO stack of signed words that reports its running minimum.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_opcode, s_value
//   m_       out  m_valid/m_ready    m_popped_value, m_current_min,
//                                    m_is_empty, m_status
//
// A push or a refused item is done when it is taken; a pop goes on to S_POP_FIN,
// for the registered read of the next top words from both stores.
// Results sit in an output register; a new item is taken while the previous
// result waits, as long as no pop is finishing and that register is free or drains in the same cycle.
// Reset is synchronous and active low, and empties the stack at once.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_opcode,
    input  wire logic signed [DATA_WIDTH-1:0] s_value,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_popped_value,
    output logic signed [DATA_WIDTH-1:0]      m_current_min,
    output logic                              m_is_empty,
    output logic [1:0]                        m_status
);
    import mts_pkg::*;

    mts_cmd_t  cmd;
    mts_stat_t stat;

    mts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mts_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_opcode       (s_opcode),
        .s_value        (s_value),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_current_min  (m_current_min),
        .m_is_empty     (m_is_empty),
        .m_status       (m_status)
    );

endmodule
`default_nettype wire

// ===== design/mts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer: takes items, and on pops waits in S_POP_FIN for the memory read.
// ----------------------------------------------------------------------------
module mts_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mts_pkg::mts_stat_t stat,
    output mts_pkg::mts_cmd_t      cmd
);
    import mts_pkg::*;

    mts_state_t state_reg, state_next;

    assign s_ready    = (state_reg == S_IDLE) && stat.out_free;
    assign cmd.accept = s_valid && s_ready;
    assign cmd.fin    = (state_reg == S_POP_FIN);
    assign cmd.load   = (cmd.accept && !stat.pop_go) || cmd.fin;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept && stat.pop_go) begin
                    state_next = S_POP_FIN;
                end
            end
            S_POP_FIN: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_fin_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |-> $past(cmd.accept && stat.pop_go))
        else $error("pop finish without a pop accept");

    a_no_accept_in_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |-> !cmd.accept)
        else $error("item taken during pop finish");

    a_one_load_per_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && stat.pop_go) |=> cmd.load)
        else $error("pop result not loaded");

endmodule
`default_nettype wire

// ===== design/mts_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_dp
// Datapath: both stores, counts, cached top words and the result register.
// ----------------------------------------------------------------------------
module mts_dp #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_opcode,
    input  wire logic signed [DATA_WIDTH-1:0] s_value,
    input  wire mts_pkg::mts_cmd_t            cmd,
    output mts_pkg::mts_stat_t                stat,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_popped_value,
    output logic signed [DATA_WIDTH-1:0]      m_current_min,
    output logic                              m_is_empty,
    output logic [1:0]                        m_status
);
    import mts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] main_mem [DEPTH];
    logic [DATA_WIDTH-1:0] min_mem  [DEPTH];

    logic [CW-1:0]         main_cnt_reg, main_cnt_next;
    logic [CW-1:0]         min_cnt_reg, min_cnt_next;
    logic [DATA_WIDTH-1:0] main_top_reg, main_top_next;
    logic [DATA_WIDTH-1:0] min_top_reg, min_top_next;
    logic [DATA_WIDTH-1:0] main_rd_reg, min_rd_reg;
    logic [DATA_WIDTH-1:0] popped_reg;
    logic                  min_dec_reg;
    logic                  m_valid_reg;
    logic [DATA_WIDTH-1:0] out_popped_reg, out_min_reg;
    logic                  out_empty_reg;
    logic [1:0]            out_status_reg;

    logic                  is_full, is_empty_now;
    logic                  main_wr, min_wr, min_dec;
    logic [AW-1:0]         main_raddr, min_raddr;
    logic [1:0]            res_status;
    logic [DATA_WIDTH-1:0] res_popped, res_min;

    assign is_full      = (main_cnt_reg == FULL_CNT);
    assign is_empty_now = (main_cnt_reg == '0);

    assign stat.pop_go   = (s_opcode == OP_POP) && !is_empty_now;
    assign stat.out_free = !m_valid_reg || m_ready;

    // push also goes on the min store when it is empty or its top is not below
    assign main_wr = cmd.accept && (s_opcode == OP_PUSH) && !is_full;
    assign min_wr  = main_wr && (min_cnt_reg != FULL_CNT) &&
                     ((min_cnt_reg == '0) ||
                      !($signed(min_top_reg) < $signed(s_value)));
    assign min_dec = (min_cnt_reg != '0) && (min_top_reg == main_top_reg);

    // next tops after a pop sit two below the current counts
    assign main_raddr = AW'(main_cnt_reg - CW'(2));
    assign min_raddr  = AW'(min_cnt_reg - CW'(2));

    always_comb begin
        main_cnt_next = main_cnt_reg;
        min_cnt_next  = min_cnt_reg;
        main_top_next = main_top_reg;
        min_top_next  = min_top_reg;
        if (cmd.fin) begin
            main_top_next = main_rd_reg;
            if (min_dec_reg) begin
                min_top_next = min_rd_reg;
            end
        end else if (cmd.accept) begin
            if (main_wr) begin
                main_cnt_next = main_cnt_reg + CW'(1);
                main_top_next = s_value;
            end
            if (min_wr) begin
                min_cnt_next = min_cnt_reg + CW'(1);
                min_top_next = s_value;
            end
            if (stat.pop_go) begin
                main_cnt_next = main_cnt_reg - CW'(1);
                if (min_dec) begin
                    min_cnt_next = min_cnt_reg - CW'(1);
                end
            end
        end
    end

    always_comb begin
        res_status = ST_OK;
        res_popped = '0;
        if (cmd.fin) begin
            res_popped = popped_reg;
        end else if ((s_opcode == OP_PUSH) && is_full) begin
            res_status = ST_FULL;
        end else if ((s_opcode == OP_POP) && is_empty_now) begin
            res_status = ST_EMPTY;
        end
        res_min = ((main_cnt_next != '0) && (min_cnt_next != '0)) ? min_top_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (main_wr) begin
            main_mem[main_cnt_reg[AW-1:0]] <= s_value;
        end
        main_rd_reg <= main_mem[main_raddr];
    end

    always_ff @(posedge aclk) begin
        if (min_wr) begin
            min_mem[min_cnt_reg[AW-1:0]] <= s_value;
        end
        min_rd_reg <= min_mem[min_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_cnt_reg <= '0;
            min_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            main_cnt_reg <= main_cnt_next;
            min_cnt_reg  <= min_cnt_next;
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        main_top_reg <= main_top_next;
        min_top_reg  <= min_top_next;
        if (cmd.accept && stat.pop_go) begin
            popped_reg  <= main_top_reg;
            min_dec_reg <= min_dec;
        end
        if (cmd.load) begin
            out_popped_reg <= res_popped;
            out_min_reg    <= res_min;
            out_empty_reg  <= (main_cnt_next == '0);
            out_status_reg <= res_status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = out_popped_reg;
    assign m_current_min  = out_min_reg;
    assign m_is_empty     = out_empty_reg;
    assign m_status       = out_status_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_cnt_reg <= FULL_CNT) && (min_cnt_reg <= main_cnt_reg))
        else $error("stack counts out of range");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    a_refused_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && (res_status != ST_OK)) |=>
            $stable(main_cnt_reg) && $stable(min_cnt_reg))
        else $error("refused item changed the stack");

endmodule
`default_nettype wire
